FILE: rtl/call_arc_counter_core_macros.svh
// Assertion macros for the call arc counter.
`ifndef CALL_ARC_COUNTER_CORE_MACROS_SVH
`define CALL_ARC_COUNTER_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("call arc counter check failed");

// Antecedent implies consequent in the next cycle.
`define CAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("call arc counter check failed");

`endif

FILE: rtl/cac_pkg.sv
// Shared types and constants of the call arc counter.
`timescale 1ns / 1ps
package cac_pkg;

    localparam int NODES      = 4096;
    localparam int BUCKETS    = 4096;
    localparam int HASH_SHIFT = 4;
    localparam int NODE_W     = $clog2(NODES);
    localparam int BUCKET_W   = $clog2(BUCKETS);
    localparam int LIMIT_W    = NODE_W + 1;
    localparam int PC_W       = 32;
    localparam int CNT_W      = 32;
    localparam int IDX_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 112;

    localparam logic [2:0] REQ_RECORD = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_HEAD   = 3'd2;
    localparam logic [2:0] REQ_NODE   = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [2:0] STS_IGNORED  = 3'd0;
    localparam logic [2:0] STS_INCR     = 3'd1;
    localparam logic [2:0] STS_CREATED  = 3'd2;
    localparam logic [2:0] STS_OVERFLOW = 3'd3;
    localparam logic [2:0] STS_FOUND    = 3'd4;
    localparam logic [2:0] STS_NOTFOUND = 3'd5;
    localparam logic [2:0] STS_DONE     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PC     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PC    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT = 2'd3;

    typedef struct packed {
        logic [PC_W-1:0]   callee;
        logic [CNT_W-1:0]  hits;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } node_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [CNT_W-1:0]  count;
        logic [PC_W-1:0]   node_pc;
        logic [IDX_W-1:0]  left_index;
        logic [IDX_W-1:0]  right_index;
        logic [IDX_W-1:0]  head_index;
    } result_t;

endpackage

FILE: rtl/call_arc_counter_core.sv
// Top level of the call arc counter: request decode, tree walk and result output.
`timescale 1ns / 1ps
// Counts caller/callee arcs in per-bucket binary trees held in a node RAM.
// One request is handled at a time. A record or look-up request that finds
// its callee reads its bucket head, then one node word per tree level visited.
// A miss, an overflow included, also passes through the miss state, and
// linking a new node below an existing one through the link state. Bucket
// reads and node reads of a nonzero index read their RAM once; ignored,
// out-of-range and unknown requests read nothing. After reset and on every
// clear request the bucket head RAM is swept, one entry a cycle. No request
// is taken during the sweep, and a clear's result follows it. A finished
// result waits in the output register while the next request is taken.
`include "call_arc_counter_core_macros.svh"
module call_arc_counter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // from_pc, self_pc, read_index, zero pad
    input  logic [cac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // count, node_pc, left_index, right_index, head_index, nodes_used
    output logic [cac_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic [2:0]                       m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [cac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cac_pkg::*;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_HEAD = 8'b0000_0100,
        S_WALK = 8'b0000_1000,
        S_MISS = 8'b0001_0000,
        S_LINK = 8'b0010_0000,
        S_NRD  = 8'b0100_0000,
        S_RESP = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            req_reg, req_next;
    logic [PC_W-1:0]       self_reg, self_next;
    logic [BUCKET_W-1:0]   bucket_reg, bucket_next;
    logic [NODE_W-1:0]     cur_reg, cur_next;
    logic [NODE_W-1:0]     last_reg, last_next;
    node_t                 last_word_reg, last_word_next;
    logic                  side_right_reg, side_right_next;
    logic [NODE_W-1:0]     alloc_reg, alloc_next;
    logic [BUCKET_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                  clr_resp_reg, clr_resp_next;
    result_t               res_reg, res_next;
    logic                  enabled_reg;
    logic [PC_W-1:0]       low_pc_reg;
    logic [PC_W-1:0]       high_pc_reg;
    logic [LIMIT_W-1:0]    node_limit_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [2:0]            out_user_reg, out_user_next;

    logic                  head_we, head_re;
    logic [BUCKET_W-1:0]   head_waddr, head_raddr;
    logic [NODE_W-1:0]     head_wdata, head_rdata;
    logic                  node_we, node_re;
    logic [NODE_W-1:0]     node_waddr, node_raddr;
    node_t                 node_wdata, node_rdata;

    logic [PC_W-1:0]       in_from, in_self, lo_aligned, diff;
    logic [IDX_W-1:0]      in_ridx;
    logic                  in_bucket_ok, accept;
    logic [NODE_W-1:0]     next_idx;
    logic [LIMIT_W-1:0]    new_idx;
    logic                  pool_full;
    node_t                 link_word;

    cac_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
    );

    cac_ram #(.WIDTH($bits(node_t)), .DEPTH(NODES)) u_node_ram (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
    );

    assign in_from    = s_axis_tdata[31:0];
    assign in_self    = s_axis_tdata[63:32];
    assign in_ridx    = s_axis_tdata[75:64];
    assign lo_aligned = {low_pc_reg[PC_W-1:HASH_SHIFT], {HASH_SHIFT{1'b0}}};
    assign diff       = in_from - lo_aligned;
    assign in_bucket_ok = (in_from >= lo_aligned) && (in_from < high_pc_reg)
                        && (diff[PC_W-1:HASH_SHIFT+BUCKET_W] == '0);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign new_idx   = {1'b0, alloc_reg} + LIMIT_W'(1);
    assign pool_full = (new_idx >= node_limit_reg) || (new_idx >= LIMIT_W'(NODES));

    always_comb
    begin
        link_word = last_word_reg;
        if (side_right_reg)
        begin
            link_word.right = alloc_reg;
        end
        else
        begin
            link_word.left = alloc_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        self_next       = self_reg;
        bucket_next     = bucket_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        last_word_next  = last_word_reg;
        side_right_next = side_right_reg;
        alloc_next      = alloc_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_resp_next   = clr_resp_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        head_we    = 1'b0;
        head_waddr = clr_cnt_reg;
        head_wdata = '0;
        head_re    = 1'b0;
        head_raddr = diff[HASH_SHIFT +: BUCKET_W];
        node_we    = 1'b0;
        node_waddr = cur_reg;
        node_wdata = node_rdata;
        node_re    = 1'b0;
        node_raddr = in_ridx[NODE_W-1:0];
        next_idx   = node_rdata.right;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                head_we      = 1'b1;
                clr_cnt_next = clr_cnt_reg + BUCKET_W'(1);
                if (clr_cnt_reg == BUCKET_W'(BUCKETS - 1))
                begin
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = s_axis_tuser;
                    self_next   = in_self;
                    bucket_next = diff[HASH_SHIFT +: BUCKET_W];
                    res_next    = '0;
                    case (s_axis_tuser)
                        REQ_RECORD, REQ_LOOKUP:
                        begin
                            if (in_bucket_ok && (enabled_reg || s_axis_tuser == REQ_LOOKUP))
                            begin
                                head_re    = 1'b1;
                                state_next = S_HEAD;
                            end
                            else
                            begin
                                res_next.status = (s_axis_tuser == REQ_LOOKUP) ?
                                                  STS_NOTFOUND : STS_IGNORED;
                                state_next = S_RESP;
                            end
                        end
                        REQ_HEAD:
                        begin
                            head_re    = 1'b1;
                            head_raddr = in_ridx[BUCKET_W-1:0];
                            state_next = S_HEAD;
                        end
                        REQ_NODE:
                        begin
                            res_next.status = STS_DONE;
                            if (in_ridx != '0)
                            begin
                                node_re    = 1'b1;
                                state_next = S_NRD;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            res_next.status = STS_DONE;
                            alloc_next      = '0;
                            clr_cnt_next    = '0;
                            clr_resp_next   = 1'b1;
                            state_next      = S_CLR;
                        end
                        default:
                        begin
                            res_next.status = STS_IGNORED;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                if (req_reg == REQ_HEAD)
                begin
                    res_next.status     = STS_DONE;
                    res_next.head_index = IDX_W'(head_rdata);
                    state_next          = S_RESP;
                end
                else if (head_rdata == '0)
                begin
                    last_next  = '0;
                    state_next = S_MISS;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = head_rdata;
                    cur_next   = head_rdata;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (node_rdata.callee == self_reg)
                begin
                    if (req_reg == REQ_LOOKUP)
                    begin
                        res_next.status = STS_FOUND;
                        res_next.count  = node_rdata.hits;
                    end
                    else
                    begin
                        node_we         = 1'b1;
                        node_wdata.hits = node_rdata.hits + CNT_W'(1);
                        res_next.status = STS_INCR;
                        res_next.count  = node_rdata.hits + CNT_W'(1);
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    if (self_reg < node_rdata.callee)
                    begin
                        next_idx = node_rdata.left;
                    end
                    last_next       = cur_reg;
                    last_word_next  = node_rdata;
                    side_right_next = !(self_reg < node_rdata.callee);
                    if (next_idx == '0)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        node_re    = 1'b1;
                        node_raddr = next_idx;
                        cur_next   = next_idx;
                    end
                end
            end
            S_MISS:
            begin
                if (req_reg == REQ_LOOKUP)
                begin
                    res_next.status = STS_NOTFOUND;
                    state_next      = S_RESP;
                end
                else if (pool_full)
                begin
                    res_next.status = STS_OVERFLOW;
                    state_next      = S_RESP;
                end
                else
                begin
                    alloc_next        = new_idx[NODE_W-1:0];
                    node_we           = 1'b1;
                    node_waddr        = new_idx[NODE_W-1:0];
                    node_wdata.callee = self_reg;
                    node_wdata.hits   = CNT_W'(1);
                    node_wdata.left   = '0;
                    node_wdata.right  = '0;
                    res_next.status   = STS_CREATED;
                    res_next.count    = CNT_W'(1);
                    if (last_reg == '0)
                    begin
                        head_we    = 1'b1;
                        head_waddr = bucket_reg;
                        head_wdata = new_idx[NODE_W-1:0];
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
            end
            S_LINK:
            begin
                node_we    = 1'b1;
                node_waddr = last_reg;
                node_wdata = link_word;
                state_next = S_RESP;
            end
            S_NRD:
            begin
                res_next.count       = node_rdata.hits;
                res_next.node_pc     = node_rdata.callee;
                res_next.left_index  = IDX_W'(node_rdata.left);
                res_next.right_index = IDX_W'(node_rdata.right);
                state_next           = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = res_reg.status;
                    out_data_next  = {IDX_W'(alloc_reg), res_reg.head_index,
                                      res_reg.right_index, res_reg.left_index,
                                      res_reg.node_pc, res_reg.count};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            alloc_reg      <= '0;
            clr_cnt_reg    <= '0;
            clr_resp_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            enabled_reg    <= 1'b0;
            low_pc_reg     <= '0;
            high_pc_reg    <= '0;
            node_limit_reg <= LIMIT_W'(NODES);
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                    CFG_LOW_PC:     low_pc_reg     <= cfg_data;
                    CFG_HIGH_PC:    high_pc_reg    <= cfg_data;
                    CFG_NODE_LIMIT: node_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:        enabled_reg    <= enabled_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        self_reg       <= self_next;
        bucket_reg     <= bucket_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        last_word_reg  <= last_word_next;
        side_right_reg <= side_right_next;
        res_reg        <= res_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `CAC_ASSERT_NEXT(a_clear_sweeps, clk, rst_n, accept && s_axis_tuser == REQ_CLEAR, state_reg == S_CLR && alloc_reg == '0)
    `CAC_ASSERT_NOW(a_created_counts, clk, rst_n, m_axis_tvalid && m_axis_tuser == STS_CREATED, m_axis_tdata[111:100] != '0 && m_axis_tdata[31:0] == 32'd1)
    `CAC_ASSERT_NOW(a_link_has_parent, clk, rst_n, state_reg == S_LINK, last_reg != '0 && alloc_reg != '0)

endmodule

FILE: rtl/cac_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module cac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
